@@ design/tdpe_pkg.sv @@
// Types, codes and microcode ROM shared by the parse engine modules.
package tdpe_pkg;

    // Width used for range checks; covers every parameter up to 1024.
    localparam int CMP_W = 11;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_TOKEN = 1'b1;

    localparam logic [2:0] ACT_ERROR  = 3'd0;
    localparam logic [2:0] ACT_SHIFT  = 3'd1;
    localparam logic [2:0] ACT_PUSH   = 3'd2;
    localparam logic [2:0] ACT_RETURN = 3'd3;
    localparam logic [2:0] ACT_ACCEPT = 3'd4;

    typedef enum logic [1:0] {
        KIND_RETURN = 2'd0,
        KIND_SHIFT  = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_ERROR  = 2'd3
    } kind_t;

    typedef struct packed {
        logic       cmd;
        logic [6:0] entry_state;
        logic [5:0] entry_symbol;
        logic [2:0] entry_action;
        logic [6:0] entry_target;
        logic [7:0] entry_sem;
        logic [5:0] token_id;
    } req_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] sem_code;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [2:0] act;
        logic [6:0] tgt;
        logic [7:0] sem;
    } entry_t;

    typedef enum logic [3:0] {
        U_IDLE,
        U_LOOKUP,
        U_DISPATCH,
        U_SHIFT,
        U_PUSH,
        U_RET,
        U_RET_RD,
        U_RET_GOTO,
        U_ACCEPT,
        U_ERROR
    } upc_t;

    typedef enum logic [1:0] {
        SEQ_GOTO,
        SEQ_TAKE,
        SEQ_DISPATCH
    } seq_t;

    typedef enum logic [2:0] {
        CHK_NONE,
        CHK_TOKEN,
        CHK_STEPS,
        CHK_SHIFT,
        CHK_PUSH,
        CHK_RET,
        CHK_GOTO
    } chk_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_TAKE,
        DP_LOOKUP,
        DP_SHIFT,
        DP_PUSH,
        DP_POP,
        DP_GOTO_RD,
        DP_GOTO,
        DP_FINISH
    } dp_op_t;

    typedef struct packed {
        seq_t   seq;
        chk_t   chk;
        dp_op_t op;
        logic   emit;
        kind_t  kind;
        logic   last;
        upc_t   next;
    } ucode_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
        kind_t  kind;
        logic   last;
    } dp_cmd_t;

    typedef struct packed {
        logic       tok_bad;
        logic       step_done;
        logic       shift_bad;
        logic       push_bad;
        logic       ret_bad;
        logic       goto_bad;
        logic       out_busy;
        logic [2:0] action;
    } dp_stat_t;

    // Control store: one word per step of the token program.
    function automatic ucode_t ucode_rom(upc_t upc);
        ucode_t w;
        begin
            unique case (upc)
                U_IDLE:     w = '{SEQ_TAKE, CHK_TOKEN, DP_TAKE, 1'b0, KIND_RETURN, 1'b0,
                                  U_LOOKUP};
                U_LOOKUP:   w = '{SEQ_GOTO, CHK_STEPS, DP_LOOKUP, 1'b0, KIND_RETURN, 1'b0,
                                  U_DISPATCH};
                U_DISPATCH: w = '{SEQ_DISPATCH, CHK_NONE, DP_NONE, 1'b0, KIND_RETURN, 1'b0,
                                  U_ERROR};
                U_SHIFT:    w = '{SEQ_GOTO, CHK_SHIFT, DP_SHIFT, 1'b1, KIND_SHIFT, 1'b1,
                                  U_IDLE};
                U_PUSH:     w = '{SEQ_GOTO, CHK_PUSH, DP_PUSH, 1'b0, KIND_RETURN, 1'b0,
                                  U_LOOKUP};
                U_RET:      w = '{SEQ_GOTO, CHK_RET, DP_POP, 1'b0, KIND_RETURN, 1'b0,
                                  U_RET_RD};
                U_RET_RD:   w = '{SEQ_GOTO, CHK_NONE, DP_GOTO_RD, 1'b0, KIND_RETURN, 1'b0,
                                  U_RET_GOTO};
                U_RET_GOTO: w = '{SEQ_GOTO, CHK_GOTO, DP_GOTO, 1'b1, KIND_RETURN, 1'b0,
                                  U_LOOKUP};
                U_ACCEPT:   w = '{SEQ_GOTO, CHK_NONE, DP_FINISH, 1'b1, KIND_ACCEPT, 1'b1,
                                  U_IDLE};
                U_ERROR:    w = '{SEQ_GOTO, CHK_NONE, DP_FINISH, 1'b1, KIND_ERROR, 1'b1,
                                  U_IDLE};
                default:    w = '{SEQ_GOTO, CHK_NONE, DP_NONE, 1'b0, KIND_RETURN, 1'b0,
                                  U_IDLE};
            endcase
            return w;
        end
    endfunction

    // Dispatch table: entry action to handler step; undefined actions fail.
    function automatic upc_t dispatch_rom(logic [2:0] act);
        upc_t u;
        begin
            unique case (act)
                ACT_SHIFT:  u = U_SHIFT;
                ACT_PUSH:   u = U_PUSH;
                ACT_RETURN: u = U_RET;
                ACT_ACCEPT: u = U_ACCEPT;
                default:    u = U_ERROR;
            endcase
            return u;
        end
    endfunction

endpackage

@@ design/tdpe_useq.sv @@
// Microcode sequencer: step counter, control store and error/dispatch jumps.
module tdpe_useq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_cmd,
    output logic                req_ready,
    input  tdpe_pkg::dp_stat_t  stat,
    output tdpe_pkg::dp_cmd_t   cmd
);

    tdpe_pkg::upc_t   upc_reg;
    tdpe_pkg::upc_t   upc_next;
    tdpe_pkg::ucode_t uw;
    logic             fault;
    logic             stall;

    assign uw = tdpe_pkg::ucode_rom(upc_reg);

    // Select the check that diverts this step to the error handler
    always_comb
    begin
        case (uw.chk)
            tdpe_pkg::CHK_TOKEN: fault = stat.tok_bad;
            tdpe_pkg::CHK_STEPS: fault = stat.step_done;
            tdpe_pkg::CHK_SHIFT: fault = stat.shift_bad;
            tdpe_pkg::CHK_PUSH:  fault = stat.push_bad;
            tdpe_pkg::CHK_RET:   fault = stat.ret_bad;
            tdpe_pkg::CHK_GOTO:  fault = stat.goto_bad;
            default:             fault = 1'b0;
        endcase
    end

    // Hold an emitting step while the result register is still occupied
    assign stall = uw.emit && stat.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= tdpe_pkg::U_IDLE;
        else
            upc_reg <= upc_next;
    end

    // Next step and issued datapath command
    always_comb
    begin
        upc_next  = upc_reg;
        cmd       = '{tdpe_pkg::DP_NONE, 1'b0, tdpe_pkg::KIND_RETURN, 1'b0};
        req_ready = 1'b0;
        unique case (uw.seq)
            tdpe_pkg::SEQ_TAKE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = uw.op;
                    if (req_cmd == tdpe_pkg::CMD_TOKEN)
                        upc_next = fault ? tdpe_pkg::U_ERROR : uw.next;
                end
            end
            tdpe_pkg::SEQ_DISPATCH:
            begin
                upc_next = tdpe_pkg::dispatch_rom(stat.action);
            end
            tdpe_pkg::SEQ_GOTO:
            begin
                if (fault)
                    upc_next = tdpe_pkg::U_ERROR;
                else if (!stall)
                begin
                    cmd      = '{uw.op, uw.emit, uw.kind, uw.last};
                    upc_next = uw.next;
                end
            end
            default:
            begin
                upc_next = tdpe_pkg::U_IDLE;
            end
        endcase
    end

endmodule

@@ design/tdpe_datapath.sv @@
// Datapath: parse table, return stack, parser registers and result register.
module tdpe_datapath #(
    parameter int NUM_STATES  = 128,
    parameter int NUM_SYMBOLS = 64,
    parameter int STACK_DEPTH = 64,
    parameter int STEP_LIMIT  = 63
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tdpe_pkg::req_t      req,
    input  tdpe_pkg::dp_cmd_t   cmd,
    output tdpe_pkg::dp_stat_t  stat,
    output logic                res_valid,
    input  logic                res_ready,
    output tdpe_pkg::res_t      res
);

    localparam int STW    = $clog2(NUM_STATES);
    localparam int SYW    = $clog2(NUM_SYMBOLS);
    localparam int AW     = STW + SYW;
    localparam int TDEPTH = 1 << AW;
    localparam int SIW    = $clog2(STACK_DEPTH);
    localparam int SPW    = $clog2(STACK_DEPTH + 1);
    localparam int SCW    = $clog2(STEP_LIMIT + 1);
    localparam int CW     = tdpe_pkg::CMP_W;

    tdpe_pkg::entry_t table_mem [TDEPTH];
    logic [STW-1:0]   stack_mem [STACK_DEPTH];

    tdpe_pkg::entry_t tab_rd_reg;
    logic [STW-1:0]   stack_rd_reg;
    logic [STW-1:0]   cur_reg,  cur_next;
    logic [SPW-1:0]   sp_reg,   sp_next;
    logic [SCW-1:0]   step_reg, step_next;
    logic [SYW-1:0]   tok_reg,  tok_next;
    logic [SYW-1:0]   col_reg,  col_next;
    logic             out_valid_reg, out_valid_next;
    tdpe_pkg::res_t   res_reg,  res_next;

    logic [CW-1:0]    row_x, ecol_x, tok_in_x, tgt_x;
    logic             load_ok;
    logic             tgt_state_bad;
    logic             wr_en, rd_en, push_en, pop_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [SPW-1:0]   sp_m1;
    tdpe_pkg::entry_t wr_data;

    // Widen fields for range checks
    assign row_x    = CW'(req.entry_state);
    assign ecol_x   = CW'(req.entry_symbol);
    assign tok_in_x = CW'(req.token_id);
    assign tgt_x    = CW'(tab_rd_reg.tgt);
    assign load_ok  = (row_x < CW'(NUM_STATES)) && (ecol_x < CW'(NUM_SYMBOLS));
    assign tgt_state_bad = (tgt_x >= CW'(NUM_STATES));
    assign sp_m1    = sp_reg - SPW'(1);

    // Status back to the sequencer
    assign stat.tok_bad   = (tok_in_x >= CW'(NUM_SYMBOLS));
    assign stat.step_done = (step_reg == SCW'(STEP_LIMIT));
    assign stat.shift_bad = tgt_state_bad;
    assign stat.push_bad  = tgt_state_bad || (sp_reg == SPW'(STACK_DEPTH));
    assign stat.ret_bad   = (sp_reg == '0) || (tgt_x >= CW'(NUM_SYMBOLS));
    assign stat.goto_bad  = tgt_state_bad;
    assign stat.out_busy  = out_valid_reg && !res_ready;
    assign stat.action    = tab_rd_reg.act;

    // Table port controls
    assign wr_en   = (cmd.op == tdpe_pkg::DP_TAKE) && (req.cmd == tdpe_pkg::CMD_LOAD) && load_ok;
    assign wr_addr = {row_x[STW-1:0], ecol_x[SYW-1:0]};
    assign wr_data = '{req.entry_action, req.entry_target, req.entry_sem};
    assign rd_en   = (cmd.op == tdpe_pkg::DP_LOOKUP) || (cmd.op == tdpe_pkg::DP_GOTO_RD);
    assign rd_addr = (cmd.op == tdpe_pkg::DP_GOTO_RD) ? {stack_rd_reg, col_reg}
                                                      : {cur_reg, tok_reg};
    assign push_en = (cmd.op == tdpe_pkg::DP_PUSH);
    assign pop_en  = (cmd.op == tdpe_pkg::DP_POP);

    // Parse table: one write port for loads, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= wr_data;
        if (rd_en)
            tab_rd_reg <= table_mem[rd_addr];
    end

    // Return stack: push writes the top slot, pop reads the slot below
    always_ff @(posedge clk)
    begin
        if (push_en)
            stack_mem[sp_reg[SIW-1:0]] <= cur_reg;
        if (pop_en)
            stack_rd_reg <= stack_mem[sp_m1[SIW-1:0]];
    end

    // Parser registers and result register next values
    always_comb
    begin
        cur_next       = cur_reg;
        sp_next        = sp_reg;
        step_next      = step_reg;
        tok_next       = tok_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg && !res_ready;
        res_next       = res_reg;
        case (cmd.op)
            tdpe_pkg::DP_TAKE:
            begin
                tok_next  = tok_in_x[SYW-1:0];
                step_next = '0;
            end
            tdpe_pkg::DP_LOOKUP:
                step_next = step_reg + SCW'(1);
            tdpe_pkg::DP_SHIFT:
                cur_next = tgt_x[STW-1:0];
            tdpe_pkg::DP_PUSH:
            begin
                sp_next  = sp_reg + SPW'(1);
                cur_next = tgt_x[STW-1:0];
            end
            tdpe_pkg::DP_POP:
            begin
                sp_next  = sp_m1;
                col_next = tgt_x[SYW-1:0];
            end
            tdpe_pkg::DP_GOTO:
                cur_next = tgt_x[STW-1:0];
            tdpe_pkg::DP_FINISH:
            begin
                cur_next = '0;
                sp_next  = '0;
            end
            default:
            begin
            end
        endcase
        // Load a result; semantic code only for shift and return results
        if (cmd.emit)
        begin
            out_valid_next    = 1'b1;
            res_next.kind     = cmd.kind;
            res_next.last     = cmd.last;
            res_next.sem_code = ((cmd.op == tdpe_pkg::DP_SHIFT) ||
                                 (cmd.op == tdpe_pkg::DP_GOTO)) ? tab_rd_reg.sem : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            sp_reg        <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            sp_reg        <= sp_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        col_reg <= col_next;
        res_reg <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= SCW'(STEP_LIMIT))
        else $error("step count beyond step limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && !res_ready))
        else $error("result written over a result not yet taken");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == tdpe_pkg::DP_FINISH) |=> (cur_reg == '0 && sp_reg == '0))
        else $error("parser not restarted after accept or error");

endmodule

@@ design/table_driven_parse_engine.sv @@
// Top level of the table-driven parse engine: sequencer plus datapath.
// Usage:
//   req channel (req_valid/req_ready/req): one item per handshake. With cmd
//   at load, the item writes one parse-table entry if in range and yields
//   no result; with cmd at token, it runs the table program for that token.
//   res channel (res_valid/res_ready/res): results in order; the final
//   result of a token carries last = 1.
// Steps: a load is written in the idle step, ready for the next item.
//   A token that shifts at once runs the take, lookup, dispatch and shift
//   steps, the shift step registering the result. Each push-goto adds
//   push, lookup and dispatch steps and each return adds pop, goto read,
//   goto, lookup and dispatch steps; table and stack reads are registered.
// Reset: the parser starts in state 0 with an empty stack and no result
//   pending. Table and stack contents are undefined until written.
// Stall: one result register sits at the output; while it is held, new
//   loads and tokens are still taken, and a step that must emit waits
//   until the held result is taken.
module table_driven_parse_engine #(
    parameter int NUM_STATES  = 128,
    parameter int NUM_SYMBOLS = 64,
    parameter int STACK_DEPTH = 64,
    parameter int STEP_LIMIT  = 63
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  tdpe_pkg::req_t  req,
    output logic            res_valid,
    input  logic            res_ready,
    output tdpe_pkg::res_t  res
);

    tdpe_pkg::dp_cmd_t  cmd;
    tdpe_pkg::dp_stat_t stat;

    // Step through the control store
    tdpe_useq u_useq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.cmd),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Execute the issued commands
    tdpe_datapath #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .STACK_DEPTH (STACK_DEPTH),
        .STEP_LIMIT  (STEP_LIMIT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule
